### hw/rtl/disjoint_set_union_find_top_macros.svh
// ----------------------------------------------------------------------------
// disjoint_set_union_find_top_macros.svh
// Assertion macros used by the disjoint-set sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_FIND_TOP_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DSU_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DSU_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define DSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

### hw/rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set table.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;
    localparam int FUNC_W = 2;

    // Command codes; the unused code behaves as find
    localparam logic [FUNC_W-1:0] FUNC_UNION = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ASK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

    // One table entry: parent link plus tree size (meaningful at roots only)
    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [SIZE_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [NODE_W-1:0] root_of_a;
        logic              same_set;
    } res_t;

    typedef struct packed {
        logic              eq;
        logic              lt;
        logic [SIZE_W-1:0] sum;
    } alu_res_t;

endpackage

### hw/rtl/dsu_cmd_if.sv
// ----------------------------------------------------------------------------
// dsu_cmd_if
// Command channel: valid/ready handshake with function code and two nodes.
// ----------------------------------------------------------------------------
interface dsu_cmd_if
    import dsu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output func, output node_a, output node_b, input ready);
    modport sink   (input valid, input func, input node_a, input node_b, output ready);
endinterface

### hw/rtl/dsu_res_if.sv
// ----------------------------------------------------------------------------
// dsu_res_if
// Result channel: valid/ready handshake with root and same-set flag.
// ----------------------------------------------------------------------------
interface dsu_res_if
    import dsu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] root_of_a;
    logic              same_set;

    modport source (output valid, output root_of_a, output same_set, input ready);
    modport sink   (input valid, input root_of_a, input same_set, output ready);
endinterface

### hw/rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/dsu_alu.sv
// ----------------------------------------------------------------------------
// dsu_alu
// Shared compare and saturating-add unit used by the sequencer.
// ----------------------------------------------------------------------------
module dsu_alu
    import dsu_pkg::*;
(
    input  logic [SIZE_W-1:0] opa,
    input  logic [SIZE_W-1:0] opb,
    output alu_res_t          res
);

    logic [SIZE_W:0] wide;

    assign wide    = {1'b0, opa} + {1'b0, opb};
    assign res.eq  = (opa == opb);
    assign res.lt  = (opa < opb);
    // Saturate at the all-ones size
    assign res.sum = wide[SIZE_W] ? {SIZE_W{1'b1}} : wide[SIZE_W-1:0];

endmodule

### hw/rtl/dsu_seq.sv
// ----------------------------------------------------------------------------
// dsu_seq
// Sequencer: clearing pass, path-halving walks and union by size.
// ----------------------------------------------------------------------------
`include "disjoint_set_union_find_top_macros.svh"

module dsu_seq
    import dsu_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    dsu_cmd_if.sink                  cmd,
    input  logic                     res_free,
    output logic                     res_load,
    output res_t                     res_data,
    output logic                     ram_we,
    output logic [$clog2(NODES)-1:0] ram_waddr,
    output logic [ENTRY_W-1:0]       ram_wdata,
    output logic                     ram_re,
    output logic [$clog2(NODES)-1:0] ram_raddr,
    input  logic [ENTRY_W-1:0]       ram_rdata
);

    localparam int AW = $clog2(NODES);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_START = 9'b000000100,
        S_PROBE = 9'b000001000,
        S_HALVE = 9'b000010000,
        S_SAME  = 9'b000100000,
        S_LINK1 = 9'b001000000,
        S_LINK2 = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     init_cnt_reg, init_cnt_next;
    logic              phase_b_reg, phase_b_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [NODE_W-1:0] node_b_reg, node_b_next;
    logic [NODE_W-1:0] p_reg, p_next;
    logic [NODE_W-1:0] ra_reg, ra_next;
    logic [NODE_W-1:0] rb_reg, rb_next;
    logic [SIZE_W-1:0] sa_reg, sa_next;
    logic [SIZE_W-1:0] sb_reg, sb_next;
    logic [SIZE_W-1:0] sum_reg, sum_next;
    logic              a_in_reg, a_in_next;
    logic              b_in_reg, b_in_next;
    logic              same_reg, same_next;

    entry_t            rd;
    entry_t            wr;
    logic [SIZE_W-1:0] alu_a, alu_b;
    alu_res_t          alu;
    logic              walk_done;
    logic [NODE_W-1:0] walk_root;
    logic [SIZE_W-1:0] walk_size;
    logic              is_pair;

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return 32'(n) < NODES;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] n);
        return AW'(32'(n));
    endfunction

    dsu_alu u_alu (
        .opa (alu_a),
        .opb (alu_b),
        .res (alu)
    );

    assign rd        = entry_t'(ram_rdata);
    assign ram_wdata = wr;
    assign is_pair   = (func_reg == FUNC_UNION) || (func_reg == FUNC_ASK);
    assign cmd.ready = (state_reg == S_IDLE);
    assign res_data  = '{root_of_a: ra_reg, same_set: same_reg};

    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        phase_b_next  = phase_b_reg;
        func_next     = func_reg;
        node_b_next   = node_b_reg;
        p_next        = p_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        sum_next      = sum_reg;
        a_in_next     = a_in_reg;
        b_in_next     = b_in_reg;
        same_next     = same_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        wr            = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        alu_a         = '0;
        alu_b         = '0;
        walk_done     = 1'b0;
        walk_root     = p_reg;
        walk_size     = rd.size;
        res_load      = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                wr        = '{parent: NODE_W'(32'(init_cnt_reg)), size: SIZE_W'(1)};
                if (init_cnt_reg == AW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next    = cmd.func;
                    node_b_next  = cmd.node_b;
                    p_next       = cmd.node_a;
                    phase_b_next = 1'b0;
                    same_next    = 1'b0;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (node_ok(p_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = to_addr(p_reg);
                    state_next = S_PROBE;
                end
                else
                begin
                    // Out-of-range node is its own root and never stored
                    walk_done = 1'b1;
                end
            end
            S_PROBE:
            begin
                alu_a = SIZE_W'(rd.parent);
                alu_b = SIZE_W'(p_reg);
                if (alu.eq)
                begin
                    walk_done = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = to_addr(rd.parent);
                    state_next = S_HALVE;
                end
            end
            S_HALVE:
            begin
                // Link p to its grandparent and continue from there
                ram_we     = 1'b1;
                ram_waddr  = to_addr(p_reg);
                wr         = '{parent: rd.parent, size: rd.size};
                ram_re     = 1'b1;
                ram_raddr  = to_addr(rd.parent);
                p_next     = rd.parent;
                state_next = S_PROBE;
            end
            S_SAME:
            begin
                alu_a     = SIZE_W'(ra_reg);
                alu_b     = SIZE_W'(rb_reg);
                same_next = alu.eq;
                if (func_reg == FUNC_UNION && !alu.eq && a_in_reg && b_in_reg)
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK1:
            begin
                alu_a    = sa_reg;
                alu_b    = sb_reg;
                sum_next = alu.sum;
                ram_we   = 1'b1;
                if (alu.lt)
                begin
                    ram_waddr = to_addr(ra_reg);
                    wr        = '{parent: rb_reg, size: sa_reg};
                    ra_next   = rb_reg;
                end
                else
                begin
                    ram_waddr = to_addr(rb_reg);
                    wr        = '{parent: ra_reg, size: sb_reg};
                end
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = to_addr(ra_reg);
                wr         = '{parent: ra_reg, size: sum_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (walk_done)
        begin
            if (!phase_b_reg)
            begin
                ra_next   = walk_root;
                sa_next   = walk_size;
                a_in_next = node_ok(walk_root);
                if (is_pair)
                begin
                    phase_b_next = 1'b1;
                    p_next       = node_b_reg;
                    state_next   = S_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            else
            begin
                rb_next    = walk_root;
                sb_next    = walk_size;
                b_in_next  = node_ok(walk_root);
                state_next = S_SAME;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            phase_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            phase_b_reg  <= phase_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        node_b_reg <= node_b_next;
        p_reg      <= p_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        sum_reg    <= sum_next;
        a_in_reg   <= a_in_next;
        b_in_reg   <= b_in_next;
        same_reg   <= same_next;
    end

    `DSU_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "table read and write hit one entry")
    `DSU_ASSERT_IMPL(a_load_free, clk, rst_n, res_load, res_free, "result loaded into a full output stage")
    `DSU_ASSERT_NEXT(a_one_cmd, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready, "second command taken while busy")

endmodule

### hw/rtl/disjoint_set_union_find_top.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_find_top
// Disjoint-set table with union by size and path halving.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------
//   cmd     | in  | func, node_a, node_b
//   res     | out | root_of_a, same_set
//
// After reset a clearing pass writes every table entry, and cmd is not
// ready until it ends.
// A walk reads the entry of its node and, until it reaches a root, relinks
// the node to its grandparent and goes on from there (path halving). A find
// walks from node_a, an ask and a union walk from both nodes, and a union
// that merges two sets then makes two table writes.
// The table has a single write port and a single registered read port.
// One command is in flight at a time; the sequencer holds in its done state
// while the output stage is full, and a result waits in the output stage
// while the next command is already taken.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_top
    import dsu_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    dsu_cmd_if.sink   cmd,
    dsu_res_if.source res
);

    localparam int AW = $clog2(NODES);

    // Table port signals between sequencer and memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Output stage
    logic res_valid_reg;
    res_t res_data_reg;
    res_t res_new;
    logic res_load;
    logic res_free;

    // One entry per node: parent link and tree size share a word
    dsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsu_seq #(
        .NODES (NODES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_free  (res_free),
        .res_load  (res_load),
        .res_data  (res_new),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // The stage can take a new result when empty or being drained this cycle
    assign res_free = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            // Drop the result once its transfer completes
            res_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the next load
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_new;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.root_of_a = res_data_reg.root_of_a;
    assign res.same_set  = res_data_reg.same_set;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disjoint-set table: union by size with path
// halving.
//
// A clocked driver pulls commands from a queue and presents them on the cmd
// channel. At each cmd transfer a local copy of the parent and size tables
// applies the same command and files the answer it should produce. A clocked
// monitor takes each res transfer and compares it, field by field, with the
// oldest filed answer.
// Stimulus is a short directed set, then random commands drawn mostly from a
// narrow node window so that sets grow into real trees, with some commands
// spread over the whole index range. The run goes through four handshake
// phases: free flow, a sparse sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module tb_top
    import dsu_pkg::*;
();

    localparam int NODE_COUNT   = 1024;        // 2**NODE_W, so every index is stored
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_CMDS   = 100;
    localparam int WINDOW       = 48;          // width of the random node window
    localparam int TAIL_CYCLES  = 50;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // unused code, acts as find
    localparam logic [SIZE_W-1:0] SIZE_CAP   = {SIZE_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } cmd_item_t;

    logic clk = 1'b0;
    logic rst_n;

    dsu_cmd_if cmd_ch();
    dsu_res_if res_ch();

    disjoint_set_union_find_top #(
        .NODES (NODE_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Shadow of the table that the block keeps
    logic [NODE_W-1:0] parent_link [NODE_COUNT];
    logic [SIZE_W-1:0] tree_size   [NODE_COUNT];

    cmd_item_t queued_cmds[$];      // waiting for a cmd transfer
    res_t      owed_answers[$];     // accepted, answer not yet seen

    int send_gap_pct   = 0;         // chance per cycle that the driver idles
    int take_stall_pct = 0;         // chance per cycle that the monitor stalls
    int fail_count     = 0;
    int cycle_count    = 0;
    int answers_seen   = 0;
    int merge_count    = 0;
    int deepest_walk   = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    // Walk to the root; on each step relink the visited node to its grandparent
    function automatic logic [NODE_W-1:0] halve_to_root(input logic [NODE_W-1:0] start);
        logic [NODE_W-1:0] here;
        logic [NODE_W-1:0] grand;
        int                hops;
        here = start;
        hops = 0;
        while (parent_link[here] != here && hops < NODE_COUNT)
        begin
            grand             = parent_link[parent_link[here]];
            parent_link[here] = grand;
            here              = grand;
            hops++;
        end
        if (hops > deepest_walk)
            deepest_walk = hops;
        return here;
    endfunction

    // Apply one accepted command to the shadow table and file its answer
    function automatic void apply_command(input cmd_item_t c);
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic [SIZE_W:0]   joined;
        logic              same;
        same   = 1'b0;
        root_a = halve_to_root(c.node_a);
        kind_count[c.func]++;
        if (c.func == FUNC_UNION || c.func == FUNC_ASK)
        begin
            root_b = halve_to_root(c.node_b);
            same   = (root_a == root_b);
            if (c.func == FUNC_UNION && !same)
            begin
                joined = tree_size[root_a] + tree_size[root_b];
                if (joined > SIZE_CAP)
                    joined = SIZE_CAP;
                // Hang the smaller tree; on a tie root_b goes under root_a
                if (tree_size[root_a] < tree_size[root_b])
                begin
                    parent_link[root_a] = root_b;
                    tree_size[root_b]   = joined[SIZE_W-1:0];
                    root_a              = root_b;
                end
                else
                begin
                    parent_link[root_b] = root_a;
                    tree_size[root_a]   = joined[SIZE_W-1:0];
                end
                merge_count++;
            end
        end
        owed_answers.push_back('{root_of_a: root_a, same_set: same});
    endfunction

    function automatic void queue_command(input logic [FUNC_W-1:0] f,
                                          input logic [NODE_W-1:0] a,
                                          input logic [NODE_W-1:0] b);
        queued_cmds.push_back('{func: f, node_a: a, node_b: b});
    endfunction

    // Mostly nodes from the window so sets merge into deep trees; the rest
    // spread over the full range to toggle every index bit
    function automatic logic [NODE_W-1:0] pick_node(input int base);
        if ($urandom_range(99, 0) < 80)
            return NODE_W'(base + $urandom_range(WINDOW - 1, 0));
        return NODE_W'($urandom_range(NODE_COUNT - 1, 0));
    endfunction

    function automatic void queue_random_command(input int base);
        int                pick;
        logic [FUNC_W-1:0] f;
        pick = $urandom_range(99, 0);
        if (pick < 45)
            f = FUNC_UNION;
        else if (pick < 70)
            f = FUNC_ASK;
        else if (pick < 90)
            f = FUNC_FIND;
        else
            f = FUNC_SPARE;
        queue_command(f, pick_node(base), pick_node(base));
    endfunction

    // Driver: present the head of the queue, hold it until the transfer,
    // idle at random between commands
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid  <= 1'b0;
            cmd_ch.func   <= FUNC_FIND;
            cmd_ch.node_a <= '0;
            cmd_ch.node_b <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                apply_command(queued_cmds.pop_front());
            // A command offered but not yet taken must stay on the bus
            if (!(cmd_ch.valid && !cmd_ch.ready))
            begin
                if (queued_cmds.size() != 0 && $urandom_range(99, 0) >= send_gap_pct)
                begin
                    cmd_ch.valid  <= 1'b1;
                    cmd_ch.func   <= queued_cmds[0].func;
                    cmd_ch.node_a <= queued_cmds[0].node_a;
                    cmd_ch.node_b <= queued_cmds[0].node_b;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each res transfer against the oldest owed answer,
    // stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                answers_seen++;
                if (owed_answers.size() == 0)
                begin
                    $error("unexpected result: root_of_a %0d same_set %0b",
                           res_ch.root_of_a, res_ch.same_set);
                    fail_count++;
                end
                else
                begin
                    res_t want;
                    want = owed_answers.pop_front();
                    if (res_ch.root_of_a !== want.root_of_a)
                    begin
                        $error("root_of_a: expected %0d, got %0d",
                               want.root_of_a, res_ch.root_of_a);
                        fail_count++;
                    end
                    if (res_ch.same_set !== want.same_set)
                    begin
                        $error("same_set: expected %0b, got %0b",
                               want.same_set, res_ch.same_set);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99, 0) >= take_stall_pct);
        end
    end

    // Watchdog: drop the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int gap_by_phase   [4];
        int stall_by_phase [4];
        int phase;
        int base;
        gap_by_phase   = '{0, 76, 0, 25};
        stall_by_phase = '{0, 0, 76, 25};

        // Hold every input at a known value through reset
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.func   = FUNC_FIND;
        cmd_ch.node_a = '0;
        cmd_ch.node_b = '0;
        res_ch.ready  = 1'b0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            parent_link[i] = NODE_W'(i);
            tree_size[i]   = SIZE_W'(1);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: index extremes, every command, tie and size-ordered
        // unions, union inside one set, the spare code, a deeper tree
        queue_command(FUNC_FIND,  10'd0,     10'd1023);
        queue_command(FUNC_FIND,  10'd1023,  10'd0);
        queue_command(FUNC_ASK,   10'd0,     10'd1023);
        queue_command(FUNC_ASK,   10'd5,     10'd5);
        queue_command(FUNC_UNION, 10'd0,     10'd1023);
        queue_command(FUNC_ASK,   10'd1023,  10'd0);
        queue_command(FUNC_UNION, 10'd0,     10'd1023);
        queue_command(FUNC_UNION, 10'd1,     10'd2);
        queue_command(FUNC_UNION, 10'd3,     10'd1);
        queue_command(FUNC_UNION, 10'd1,     10'd0);
        queue_command(FUNC_SPARE, 10'd1023,  10'd1023);
        queue_command(FUNC_FIND,  10'd1023,  10'd512);
        queue_command(FUNC_UNION, 10'h2AA,   10'h155);
        queue_command(FUNC_ASK,   10'h155,   10'h2AA);
        queue_command(FUNC_UNION, 10'd4,     10'd5);
        queue_command(FUNC_UNION, 10'd6,     10'd7);
        queue_command(FUNC_UNION, 10'd4,     10'd6);
        queue_command(FUNC_UNION, 10'd8,     10'd9);
        queue_command(FUNC_UNION, 10'd10,    10'd11);
        queue_command(FUNC_UNION, 10'd8,     10'd10);
        queue_command(FUNC_UNION, 10'd4,     10'd8);
        queue_command(FUNC_FIND,  10'd11,    10'd0);
        queue_command(FUNC_SPARE, 10'd11,    10'h3FF);

        for (phase = 0; phase < 4; phase++)
        begin
            send_gap_pct   = gap_by_phase[phase];
            take_stall_pct = stall_by_phase[phase];
            base = $urandom_range(NODE_COUNT - WINDOW, 0);
            repeat (PHASE_CMDS) queue_random_command(base);
            // Hold off the next phase until every owed answer is back
            while (queued_cmds.size() != 0 || owed_answers.size() != 0)
                @(posedge clk);
        end

        // Watch for stray results a little longer
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d union, %0d ask, %0d find, %0d spare code",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[FUNC_UNION], kind_count[FUNC_ASK],
                 kind_count[FUNC_FIND], kind_count[FUNC_SPARE]);
        $display("%0d results checked, %0d sets merged, longest root walk %0d links",
                 answers_seen, merge_count, deepest_walk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### disjoint_set_union_find_top.f
+incdir+hw/rtl
hw/rtl/dsu_pkg.sv
hw/rtl/dsu_cmd_if.sv
hw/rtl/dsu_res_if.sv
hw/rtl/dsu_ram.sv
hw/rtl/dsu_alu.sv
hw/rtl/dsu_seq.sv
hw/rtl/disjoint_set_union_find_top.sv
tb/sv/tb_top.sv
